// ----- src/aetf_pkg.sv -----
// aetf_pkg: shared types, constants and byte codes for the escape filter
// used by aetf_front, aetf_cmd_queue, aetf_back and the top level
// no dependencies
package aetf_pkg;

    // parameter buffer depth (2..62)
    localparam int PARAM_DEPTH = 16;
    // count saturates at PARAM_DEPTH + 1 to mark overflow
    localparam int CNT_W = $clog2(PARAM_DEPTH + 2);
    localparam int IDX_W = $clog2(PARAM_DEPTH);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PARAM_DEPTH);
    localparam logic [CNT_W-1:0] OVER_C  = CNT_W'(PARAM_DEPTH + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] CSI_OPEN    = 8'h5B;
    localparam logic [7:0] PARAM_LO    = 8'h20;
    localparam logic [7:0] PARAM_HI    = 8'h3F;
    localparam logic [7:0] FINAL_CLEAR = 8'h4A;
    localparam logic [7:0] FINAL_HOME  = 8'h48;
    localparam logic [7:0] ARG_TWO     = 8'h32;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ACT_PRINT = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_HOME  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CMD_CHAR     = 3'd0,
        CMD_ESC_CHAR = 3'd1,
        CMD_CLEAR    = 3'd2,
        CMD_HOME     = 3'd3,
        CMD_REPLAY   = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       ch;
        logic [CNT_W-1:0] nparams;
        logic             drop;
    } cmd_t;

endpackage

// ----- src/ansi_escape_terminal_filter_unit.sv -----
// path: a byte that gives a result is registered in the command queue, then in the output register
// throughput: one byte per cycle while the command queue has room and no replay holds
//   input off; a cut-off sequence replays ESC, the bracket and its n buffered parameters
//   as n + 2 results, and input is held off until the replay has read the buffer
// reset: rst_n async active low; phase idle, parameter count zero, queue and output empty
// ansi_escape_terminal_filter_unit: top level, front -> command queue -> back
module ansi_escape_terminal_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side: one byte of the write stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_write
    // master side: one display request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [8] params_dropped, [15:9] zero
    output logic [1:0]  m_tuser,   // [1:0] action
    output logic        m_tlast    // run_last
);

    // command handoff between front and back
    logic                       push;
    aetf_pkg::cmd_t             push_cmd;
    logic                       queue_full;
    logic                       pop;
    logic                       head_valid;
    aetf_pkg::cmd_t             head_cmd;
    logic                       replay_done;
    // parameter buffer read port, used by the back during replays
    logic [aetf_pkg::IDX_W-1:0] rd_idx;
    logic [7:0]                 rd_data;
    // result fields
    logic [7:0]                 out_char;
    logic                       out_drop;

    // front: classify bytes, keep escape phase and parameter buffer
    aetf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_eow      (s_tlast),
        .push        (push),
        .push_cmd    (push_cmd),
        .queue_full  (queue_full),
        .replay_done (replay_done),
        .rd_idx      (rd_idx),
        .rd_data     (rd_data)
    );

    // short queue decouples the two sides
    aetf_cmd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back: one result request per cycle into the output register while it is empty or being taken
    aetf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .replay_done (replay_done),
        .rd_idx      (rd_idx),
        .rd_data     (rd_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_action  (m_tuser),
        .out_char    (out_char),
        .out_last    (m_tlast),
        .out_drop    (out_drop)
    );

    // pack payload, zero fill to whole bytes
    assign m_tdata = {7'b0, out_drop, out_char};

endmodule

// ----- src/aetf_front.sv -----
// aetf_front: accepts bytes, tracks escape phase, buffers parameters
// and turns each byte into at most one command for the back end
// depends on aetf_pkg
module aetf_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       in_eow,
    output logic                       push,
    output aetf_pkg::cmd_t             push_cmd,
    input  logic                       queue_full,
    input  logic                       replay_done,
    input  logic [aetf_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]                 rd_data
);

    aetf_pkg::phase_t               phase_reg, phase_next;
    logic [aetf_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [7:0]                     store_reg [aetf_pkg::PARAM_DEPTH];
    logic                           lock_reg, lock_next;
    logic                           accept;
    logic                           is_param;
    logic                           has_room;
    logic [aetf_pkg::CNT_W-1:0]     count_bump;
    logic                           emit;
    aetf_pkg::cmd_t                 cmd;

    assign in_ready = !queue_full && !lock_reg;
    assign accept   = in_valid && in_ready;
    assign is_param = in_byte inside {[aetf_pkg::PARAM_LO:aetf_pkg::PARAM_HI]};
    assign has_room = count_reg < aetf_pkg::DEPTH_C;
    assign count_bump = has_room ? count_reg + aetf_pkg::CNT_W'(1) : aetf_pkg::OVER_C;
    assign rd_data  = store_reg[rd_idx];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                aetf_pkg::PH_ESC:
                begin
                    if (in_byte == aetf_pkg::CSI_OPEN)
                        phase_next = in_eow ? aetf_pkg::PH_IDLE : aetf_pkg::PH_CSI;
                    else if (in_byte == aetf_pkg::ESC_BYTE && !in_eow)
                        phase_next = aetf_pkg::PH_ESC;
                    else
                        phase_next = aetf_pkg::PH_IDLE;
                end
                aetf_pkg::PH_CSI:
                begin
                    phase_next = (is_param && !in_eow) ? aetf_pkg::PH_CSI
                                                       : aetf_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = (in_byte == aetf_pkg::ESC_BYTE && !in_eow)
                                 ? aetf_pkg::PH_ESC : aetf_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // command for this byte
    always_comb
    begin
        emit        = 1'b0;
        cmd.kind    = aetf_pkg::CMD_CHAR;
        cmd.ch      = in_byte;
        cmd.nparams = '0;
        cmd.drop    = 1'b0;
        count_next  = count_reg;
        case (phase_reg)
            aetf_pkg::PH_ESC:
            begin
                if (in_byte == aetf_pkg::CSI_OPEN)
                begin
                    if (in_eow)
                    begin
                        emit     = 1'b1;
                        cmd.kind = aetf_pkg::CMD_REPLAY;
                    end
                    else
                        count_next = '0;
                end
                else if (in_byte == aetf_pkg::ESC_BYTE && !in_eow)
                begin
                    // stale escape printed, new one pending
                    emit   = 1'b1;
                    cmd.ch = aetf_pkg::ESC_BYTE;
                end
                else
                begin
                    emit     = 1'b1;
                    cmd.kind = aetf_pkg::CMD_ESC_CHAR;
                end
            end
            aetf_pkg::PH_CSI:
            begin
                if (is_param)
                begin
                    count_next = count_bump;
                    if (in_eow)
                    begin
                        emit        = 1'b1;
                        cmd.kind    = aetf_pkg::CMD_REPLAY;
                        cmd.drop    = !has_room;
                        cmd.nparams = has_room ? count_bump : aetf_pkg::DEPTH_C;
                    end
                end
                else if (in_byte == aetf_pkg::FINAL_CLEAR && count_reg == aetf_pkg::CNT_W'(1)
                         && store_reg[0] == aetf_pkg::ARG_TWO)
                begin
                    emit     = 1'b1;
                    cmd.kind = aetf_pkg::CMD_CLEAR;
                end
                else if (in_byte == aetf_pkg::FINAL_HOME && count_reg == '0)
                begin
                    emit     = 1'b1;
                    cmd.kind = aetf_pkg::CMD_HOME;
                end
            end
            default:
            begin
                emit = !(in_byte == aetf_pkg::ESC_BYTE && !in_eow);
            end
        endcase
    end

    assign push     = accept && emit;
    assign push_cmd = cmd;

    // hold input while a replay still reads the buffer
    always_comb
    begin
        lock_next = lock_reg;
        if (replay_done)
            lock_next = 1'b0;
        if (push && cmd.kind == aetf_pkg::CMD_REPLAY)
            lock_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aetf_pkg::PH_IDLE;
            count_reg <= '0;
            lock_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            lock_reg  <= lock_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == aetf_pkg::PH_CSI && is_param && has_room)
            store_reg[count_reg[aetf_pkg::IDX_W-1:0]] <= in_byte;
    end

    a_lock_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> !in_ready)
        else $error("input taken while replay pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= aetf_pkg::OVER_C)
        else $error("parameter count out of range");

endmodule

// ----- src/aetf_cmd_queue.sv -----
// aetf_cmd_queue: small command fifo between front and back
// depends on aetf_pkg
module aetf_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aetf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output aetf_pkg::cmd_t head_cmd
);

    aetf_pkg::cmd_t            entry_reg [aetf_pkg::QUEUE_DEPTH];
    logic [aetf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [aetf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [aetf_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        do_pop;

    assign full       = count_reg == (aetf_pkg::QPTR_W+1)'(aetf_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + aetf_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + aetf_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + (aetf_pkg::QPTR_W+1)'(1);
        else if (!push && do_pop)
            count_next = count_reg - (aetf_pkg::QPTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- src/aetf_back.sv -----
// aetf_back: expands queued commands into result requests, one per cycle while
// the output register can load, reading the front's buffered parameters for replays
// depends on aetf_pkg
module aetf_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  aetf_pkg::cmd_t             head_cmd,
    output logic                       pop,
    output logic                       replay_done,
    output logic [aetf_pkg::IDX_W-1:0] rd_idx,
    input  logic [7:0]                 rd_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 out_action,
    output logic [7:0]                 out_char,
    output logic                       out_last,
    output logic                       out_drop
);

    logic [aetf_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [aetf_pkg::CNT_W-1:0] idx_full;
    logic                       valid_reg;
    aetf_pkg::action_t          action_reg, act;
    logic [7:0]                 char_reg, ch;
    logic                       last_reg, last;
    logic                       drop_reg;
    logic                       load;
    logic                       gen;

    assign load     = !valid_reg || out_ready;
    assign gen      = load && head_valid;
    assign idx_full = pos_reg - aetf_pkg::CNT_W'(2);
    assign rd_idx   = idx_full[aetf_pkg::IDX_W-1:0];

    always_comb
    begin
        act  = aetf_pkg::ACT_PRINT;
        ch   = head_cmd.ch;
        last = 1'b1;
        case (head_cmd.kind)
            aetf_pkg::CMD_ESC_CHAR:
            begin
                ch   = (pos_reg == '0) ? aetf_pkg::ESC_BYTE : head_cmd.ch;
                last = pos_reg != '0;
            end
            aetf_pkg::CMD_CLEAR:
            begin
                act = aetf_pkg::ACT_CLEAR;
                ch  = 8'h00;
            end
            aetf_pkg::CMD_HOME:
            begin
                act = aetf_pkg::ACT_HOME;
                ch  = 8'h00;
            end
            aetf_pkg::CMD_REPLAY:
            begin
                if (pos_reg == '0)
                    ch = aetf_pkg::ESC_BYTE;
                else if (pos_reg == aetf_pkg::CNT_W'(1))
                    ch = aetf_pkg::CSI_OPEN;
                else
                    ch = rd_data;
                last = pos_reg == head_cmd.nparams + aetf_pkg::CNT_W'(1);
            end
            default:
            begin
                ch = head_cmd.ch;
            end
        endcase
    end

    assign pop         = gen && last;
    assign replay_done = pop && head_cmd.kind == aetf_pkg::CMD_REPLAY;

    always_comb
    begin
        pos_next = pos_reg;
        if (gen)
            pos_next = last ? '0 : pos_reg + aetf_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (load)
                valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            action_reg <= act;
            char_reg   <= ch;
            last_reg   <= last;
            drop_reg   <= head_cmd.kind == aetf_pkg::CMD_REPLAY && head_cmd.drop;
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_char   = char_reg;
    assign out_last   = last_reg;
    assign out_drop   = drop_reg;

    a_ctrl_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action != aetf_pkg::ACT_PRINT |-> out_last && out_char == 8'h00)
        else $error("clear or home request not single and blank");

    a_drop_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_drop |-> out_action == aetf_pkg::ACT_PRINT)
        else $error("drop flag on non-print request");

    a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> pos_reg == '0)
        else $error("position not cleared after command done");

endmodule

// ----- bench/display_request_checker.sv -----
// display_request_checker: watches both stream sides of the escape filter,
// predicts the display requests from the accepted bytes and compares them
// depends on aetf_pkg for byte codes, phase and action encodings
module display_request_checker
    import aetf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_write
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] out_char, [8] params_dropped, [15:9] zero
    input  logic [1:0]  m_tuser,   // [1:0] action
    input  logic        m_tlast,   // run_last
    output int          fail_count,
    output int          open_count,
    output int          bytes_seen,
    output int          requests_seen,
    output int          clears_seen,
    output int          homes_seen,
    output int          dropped_seen
);

    typedef struct {
        logic [1:0] act;
        logic [7:0] ch;
        logic       run_last;
        logic       dropped;
    } disp_req_t;

    disp_req_t  due_requests[$];
    disp_req_t  run_reqs[$];

    // own copy of the filter state
    phase_t     esc_phase = PH_IDLE;
    logic [7:0] arg_buf [PARAM_DEPTH];
    int         arg_cnt = 0;

    int n_fail    = 0;
    int n_bytes   = 0;
    int n_reqs    = 0;
    int n_clears  = 0;
    int n_homes   = 0;
    int n_dropped = 0;

    function automatic void add_req(input logic [1:0] act, input logic [7:0] ch,
                                    input logic dropped);
        disp_req_t r;
        r.act      = act;
        r.ch       = ch;
        r.run_last = 1'b0;
        r.dropped  = dropped;
        run_reqs.push_back(r);
    endfunction

    // byte with no escape pending
    function automatic void plain_byte(input logic [7:0] b, input logic eow);
        if (b == ESC_BYTE && !eow)
            esc_phase = PH_ESC;
        else
        begin
            esc_phase = PH_IDLE;
            add_req(ACT_PRINT, b, 1'b0);
        end
    endfunction

    task automatic filter_byte(input logic [7:0] b, input logic eow);
        int   n;
        logic dropped;
        run_reqs.delete();
        case (esc_phase)
            PH_ESC:
            begin
                if (b == CSI_OPEN && eow)
                begin
                    add_req(ACT_PRINT, ESC_BYTE, 1'b0);
                    add_req(ACT_PRINT, CSI_OPEN, 1'b0);
                    esc_phase = PH_IDLE;
                end
                else if (b == CSI_OPEN)
                begin
                    esc_phase = PH_CSI;
                    arg_cnt   = 0;
                end
                else
                begin
                    add_req(ACT_PRINT, ESC_BYTE, 1'b0);
                    plain_byte(b, eow);
                end
            end
            PH_CSI:
            begin
                if (b >= PARAM_LO && b <= PARAM_HI)
                begin
                    if (arg_cnt < PARAM_DEPTH)
                    begin
                        arg_buf[arg_cnt] = b;
                        arg_cnt++;
                    end
                    else
                        arg_cnt = PARAM_DEPTH + 1;
                    if (eow)
                    begin
                        // cut off: replay what was buffered
                        dropped = (arg_cnt > PARAM_DEPTH);
                        n       = dropped ? PARAM_DEPTH : arg_cnt;
                        add_req(ACT_PRINT, ESC_BYTE, dropped);
                        add_req(ACT_PRINT, CSI_OPEN, dropped);
                        for (int i = 0; i < n; i++)
                            add_req(ACT_PRINT, arg_buf[i], dropped);
                        if (dropped)
                            n_dropped++;
                        esc_phase = PH_IDLE;
                    end
                end
                else
                begin
                    if (b == FINAL_CLEAR && arg_cnt == 1 && arg_buf[0] == ARG_TWO)
                    begin
                        add_req(ACT_CLEAR, 8'h00, 1'b0);
                        n_clears++;
                    end
                    else if (b == FINAL_HOME && arg_cnt == 0)
                    begin
                        add_req(ACT_HOME, 8'h00, 1'b0);
                        n_homes++;
                    end
                    esc_phase = PH_IDLE;
                end
            end
            default: plain_byte(b, eow);
        endcase
        if (run_reqs.size() > 0)
            run_reqs[run_reqs.size() - 1].run_last = 1'b1;
        foreach (run_reqs[i])
            due_requests.push_back(run_reqs[i]);
    endtask

    task automatic check_request();
        disp_req_t want;
        if (due_requests.size() == 0)
        begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: unexpected request act %0d char %02h last %0b drop %0b",
                         $time, m_tuser, m_tdata[7:0], m_tlast, m_tdata[8]);
        end
        else
        begin
            want = due_requests.pop_front();
            if (m_tuser !== want.act || m_tdata[7:0] !== want.ch ||
                m_tdata[8] !== want.dropped || m_tlast !== want.run_last)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("%0t: mismatch, expected act %0d char %02h last %0b drop %0b, %s",
                             $time, want.act, want.ch, want.run_last, want.dropped,
                             $sformatf("got act %0d char %02h last %0b drop %0b",
                                       m_tuser, m_tdata[7:0], m_tlast, m_tdata[8]));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                filter_byte(s_tdata, s_tlast);
                n_bytes++;
            end
            if (m_tvalid && m_tready)
            begin
                check_request();
                n_reqs++;
            end
        end
        fail_count    <= n_fail;
        open_count    <= due_requests.size();
        bytes_seen    <= n_bytes;
        requests_seen <= n_reqs;
        clears_seen   <= n_clears;
        homes_seen    <= n_homes;
        dropped_seen  <= n_dropped;
    end

endmodule

// ----- bench/testbench.sv -----
// testbench: stimulus, reset, stall control and verdict for the escape filter
// depends on aetf_pkg, ansi_escape_terminal_filter_unit and display_request_checker
module testbench;
    import aetf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 450;
    localparam int SEGMENT        = 120;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int open_count;
    int bytes_seen;
    int requests_seen;
    int clears_seen;
    int homes_seen;
    int dropped_seen;

    // calm: no idling on either side; hold_rx: one long receiver hold-off
    bit calm    = 1'b0;
    bit hold_rx = 1'b0;

    int n_sent      = 0;
    int idle_cycles = 0;

    // one byte of a write, queued before it is offered
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wr_byte_t;

    wr_byte_t burst[$];

    always #5 clk = ~clk;

    ansi_escape_terminal_filter_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),   // end_of_write
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_char, [8] params_dropped, [15:9] zero
        .m_tuser  (m_tuser),   // [1:0] action
        .m_tlast  (m_tlast)    // run_last
    );

    display_request_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .bytes_seen    (bytes_seen),
        .requests_seen (requests_seen),
        .clears_seen   (clears_seen),
        .homes_seen    (homes_seen),
        .dropped_seen  (dropped_seen)
    );

    // watchdog: cycles in a row with no request accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver: random stall before each display request, one long hold-off on demand
    initial
    begin : receiver
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (hold_rx)
            begin
                // block fills up and must stall its input meanwhile
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic put(input logic [7:0] d, input logic l);
        burst.push_back({d, l});
    endtask

    // n random parameter bytes, none ending the write
    task automatic add_params(input int n);
        repeat (n) put(8'($urandom_range(PARAM_LO, PARAM_HI)), 1'b0);
    endtask

    // offer one byte after a random gap, return at the edge that accepts it
    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    task automatic flush_burst();
        wr_byte_t w;
        while (burst.size() > 0)
        begin
            w = burst.pop_front();
            send_byte(w.data, w.last);
        end
    endtask

    // sender pause until every predicted display request has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
    endtask

    initial
    begin : stimulus
        int         pick;
        int         kind;
        int         n;
        int         seg;
        int         mark;
        int         goal;
        logic [7:0] fin;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        put(8'h00, 1'b0);                   // byte extremes as plain text
        put(8'hFF, 1'b1);
        put(ESC_BYTE, 1'b0);                // clear display
        put(CSI_OPEN, 1'b0);
        put(ARG_TWO, 1'b0);
        put(FINAL_CLEAR, 1'b0);
        put(ESC_BYTE, 1'b0);                // cursor home
        put(CSI_OPEN, 1'b0);
        put(FINAL_HOME, 1'b0);
        put(ESC_BYTE, 1'b1);                // escape ending a write prints literally
        put(ESC_BYTE, 1'b0);                // escape then ordinary byte
        put(8'h41, 1'b0);
        put(ESC_BYTE, 1'b0);                // escape then escape opening a sequence
        put(ESC_BYTE, 1'b0);
        put(CSI_OPEN, 1'b0);
        put(FINAL_HOME, 1'b1);
        put(ESC_BYTE, 1'b0);                // write cut right after the bracket
        put(CSI_OPEN, 1'b1);
        put(ESC_BYTE, 1'b0);                // cut with parameter range extremes
        put(CSI_OPEN, 1'b0);
        put(PARAM_LO, 1'b0);
        put(PARAM_HI, 1'b1);
        put(ESC_BYTE, 1'b0);                // escape as final byte is swallowed
        put(CSI_OPEN, 1'b0);
        put(8'h33, 1'b0);
        put(ESC_BYTE, 1'b0);
        flush_burst();
        drain();

        // random part in segments, idle-free every third, long hold in the third
        seg  = 0;
        mark = n_sent + SEGMENT;
        goal = n_sent + RANDOM_ITEMS;
        while (n_sent < goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
            begin
                // well-formed control sequence with random content
                put(ESC_BYTE, 1'b0);
                put(CSI_OPEN, 1'b0);
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2:
                    begin
                        put(ARG_TWO, 1'b0);
                        fin = FINAL_CLEAR;
                    end
                    3, 4: fin = FINAL_HOME;
                    5, 6:
                    begin
                        add_params($urandom_range(0, 3));
                        case ($urandom_range(0, 2))
                            0:       fin = FINAL_CLEAR;
                            1:       fin = FINAL_HOME;
                            default: fin = 8'($urandom_range(8'h40, 8'h7E));
                        endcase
                    end
                    7:
                    begin
                        // around the buffer depth: full, and overflowed
                        add_params($urandom_range(PARAM_DEPTH - 1, PARAM_DEPTH + 4));
                        fin = $urandom_range(0, 1) ? FINAL_CLEAR : FINAL_HOME;
                    end
                    8:
                    begin
                        // near misses of the two recognized commands
                        if ($urandom_range(0, 1))
                        begin
                            add_params(1);
                            fin = FINAL_CLEAR;
                        end
                        else
                        begin
                            put(ARG_TWO, 1'b0);
                            fin = FINAL_HOME;
                        end
                    end
                    default:
                    begin
                        // any non-parameter final byte, escape included
                        add_params($urandom_range(0, 2));
                        fin = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h1F))
                                                   : 8'($urandom_range(8'h40, 8'hFF));
                    end
                endcase
                put(fin, $urandom_range(0, 3) == 0);
            end
            else if (pick < 15)
            begin
                // plain text
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put(8'($urandom_range(0, 255)), (i == n - 1) && $urandom_range(0, 1));
            end
            else if (pick < 17)
            begin
                // sequence cut off by the end of the write
                n = ($urandom_range(0, 3) == 0) ?
                    $urandom_range(PARAM_DEPTH - 1, PARAM_DEPTH + 4) : $urandom_range(0, 4);
                put(ESC_BYTE, 1'b0);
                if (n == 0)
                    put(CSI_OPEN, 1'b1);
                else
                begin
                    put(CSI_OPEN, 1'b0);
                    add_params(n - 1);
                    put(8'($urandom_range(PARAM_LO, PARAM_HI)), 1'b1);
                end
            end
            else if (pick < 19)
            begin
                // escape not opening a sequence
                if ($urandom_range(0, 2) == 0)
                    put(ESC_BYTE, 1'b1);
                else
                begin
                    put(ESC_BYTE, 1'b0);
                    fin = 8'($urandom_range(0, 255));
                    if (fin == CSI_OPEN)
                        fin = ESC_BYTE;
                    put(fin, $urandom_range(0, 3) == 0);
                end
            end
            else
                put(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);   // noise
            flush_burst();

            if (n_sent >= mark)
            begin
                drain();
                seg++;
                mark += SEGMENT;
                calm = (seg % 3 == 1);
                if (seg == 2)
                    hold_rx = 1'b1;
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d bytes in, %0d display requests checked", bytes_seen,
                 requests_seen);
        $display("including %0d clears, %0d homes, %0d replays with dropped parameters",
                 clears_seen, homes_seen, dropped_seen);
        if (open_count != 0)
            $display("%0d display requests never arrived", open_count);
        if (fail_count == 0 && open_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
src/aetf_pkg.sv
src/aetf_front.sv
src/aetf_cmd_queue.sv
src/aetf_back.sv
src/ansi_escape_terminal_filter_unit.sv
bench/display_request_checker.sv
bench/testbench.sv
